@@ rtl/cpr_pkg.sv @@
// cpr_pkg: shared types and constants for the COBS packet receive demux.
// Holds the payload structs, kind and mode codes, and the framing constants.
// No dependencies.
`timescale 1ns / 1ps

package cpr_pkg;

	// framing constants
	localparam logic [7:0] HDR_FLAG      = 8'h80;
	localparam logic [7:0] DELIM         = 8'h00;
	localparam logic [7:0] MAX_LEN_RESET = 8'd253;

	typedef enum logic [0:0] {
		OP_BYTE = 1'b0,
		OP_ARM  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		MODE_CHAR    = 2'd0,
		MODE_DISCARD = 2'd1,
		MODE_CODE    = 2'd2,
		MODE_DATA    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		KIND_TEXT     = 3'd0,
		KIND_DATA     = 3'd1,
		KIND_DONE     = 3'd2,
		KIND_EARLY    = 3'd3,
		KIND_LONG     = 3'd4,
		KIND_NOLISTEN = 3'd5
	} kind_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] line_byte;
		logic [1:0] arm_slot;
	} in_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [1:0] slot;
		logic [7:0] value;
	} out_item_t;

endpackage

@@ rtl/cpr_cfg_regs.sv @@
// cpr_cfg_regs: listener header registers and packet length limit.
// Write-only register file on a write-enable port. Depends on cpr_pkg.
`timescale 1ns / 1ps

module cpr_cfg_regs #(
	parameter int LISTEN_SLOTS = 4,
	parameter int IDX_W        = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [IDX_W-1:0]             wr_index,
	input  logic [7:0]                   wr_data,
	output logic [LISTEN_SLOTS-1:0][7:0] headers,
	output logic [7:0]                   max_len
);

	logic [LISTEN_SLOTS-1:0][7:0] headers_q;
	logic [7:0]                   max_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			headers_q <= '0;
			max_len_q <= cpr_pkg::MAX_LEN_RESET;
		end else if (wr_en) begin
			for (int s = 0; s < LISTEN_SLOTS; s++) begin
				if (wr_index == IDX_W'(s)) begin
					headers_q[s] <= wr_data;
				end
			end
			// indices past the limit register are ignored
			if (wr_index == IDX_W'(LISTEN_SLOTS)) begin
				max_len_q <= wr_data;
			end
		end
	end

	assign headers = headers_q;
	assign max_len = max_len_q;

endmodule

@@ rtl/cpr_rx_core.sv @@
// cpr_rx_core: receive state machine and on-the-fly COBS decode of one item.
// Holds mode, armed slots, active slot, byte count and code countdown.
// Depends on cpr_pkg.
`timescale 1ns / 1ps

module cpr_rx_core #(
	parameter int LISTEN_SLOTS = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step_en,
	input  cpr_pkg::in_item_t            item,
	input  logic [LISTEN_SLOTS-1:0][7:0] headers,
	input  logic [7:0]                   max_len,
	output logic                         emit,
	output cpr_pkg::out_item_t           result
);

	localparam logic [LISTEN_SLOTS-1:0] SLOT_ONE = LISTEN_SLOTS'(1);

	cpr_pkg::mode_t          mode_q, mode_nx;
	logic [LISTEN_SLOTS-1:0] armed_q, armed_nx;
	logic [1:0]              active_slot_q, active_slot_nx;
	logic [7:0]              byte_count_q, byte_count_nx;
	logic [7:0]              countdown_q, countdown_nx;

	logic       hit;
	logic [1:0] hit_slot;
	logic [7:0] cd_dec;
	logic [7:0] b;

	assign b      = item.line_byte;
	assign cd_dec = countdown_q - 8'd1;

	// lowest armed slot whose header matches wins
	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int s = LISTEN_SLOTS - 1; s >= 0; s--) begin
			if (armed_q[s] && headers[s] == b) begin
				hit      = 1'b1;
				hit_slot = 2'(s);
			end
		end
	end

	always_comb begin
		mode_nx        = mode_q;
		armed_nx       = armed_q;
		active_slot_nx = active_slot_q;
		byte_count_nx  = byte_count_q;
		countdown_nx   = countdown_q;
		emit           = 1'b0;
		result.kind    = cpr_pkg::KIND_TEXT;
		result.slot    = '0;
		result.value   = '0;

		if (item.operation == cpr_pkg::OP_ARM) begin
			if (32'(item.arm_slot) < LISTEN_SLOTS) begin
				armed_nx = armed_q | (SLOT_ONE << item.arm_slot);
			end
		end else begin
			case (mode_q)
				cpr_pkg::MODE_CHAR: begin
					if ((b & cpr_pkg::HDR_FLAG) == 8'h00) begin
						// delimiter in text is dropped
						if (b != cpr_pkg::DELIM) begin
							emit         = 1'b1;
							result.value = b;
						end
					end else if (hit) begin
						active_slot_nx = hit_slot;
						byte_count_nx  = '0;
						mode_nx        = cpr_pkg::MODE_CODE;
					end else begin
						mode_nx      = cpr_pkg::MODE_DISCARD;
						emit         = 1'b1;
						result.kind  = cpr_pkg::KIND_NOLISTEN;
						result.value = b;
					end
				end
				cpr_pkg::MODE_DISCARD: begin
					if (b == cpr_pkg::DELIM) begin
						mode_nx = cpr_pkg::MODE_CHAR;
					end
				end
				cpr_pkg::MODE_CODE: begin
					if (b == cpr_pkg::DELIM) begin
						mode_nx     = cpr_pkg::MODE_CHAR;
						emit        = 1'b1;
						result.kind = cpr_pkg::KIND_EARLY;
						result.slot = active_slot_q;
					end else begin
						countdown_nx = b;
						mode_nx      = cpr_pkg::MODE_DATA;
					end
				end
				cpr_pkg::MODE_DATA: begin
					emit        = 1'b1;
					result.slot = active_slot_q;
					if (b == cpr_pkg::DELIM) begin
						armed_nx     = armed_q & ~(SLOT_ONE << active_slot_q);
						mode_nx      = cpr_pkg::MODE_CHAR;
						result.kind  = cpr_pkg::KIND_DONE;
						result.value = byte_count_q;
					end else if (byte_count_q >= max_len) begin
						mode_nx     = cpr_pkg::MODE_DISCARD;
						result.kind = cpr_pkg::KIND_LONG;
					end else begin
						byte_count_nx = byte_count_q + 8'd1;
						result.kind   = cpr_pkg::KIND_DATA;
						// countdown expiry marks a COBS code byte: decodes to zero
						if (cd_dec == 8'h00) begin
							countdown_nx = b;
							result.value = 8'h00;
						end else begin
							countdown_nx = cd_dec;
							result.value = b;
						end
					end
				end
				default: begin
					mode_nx = cpr_pkg::MODE_CHAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= cpr_pkg::MODE_CHAR;
			armed_q       <= '0;
			active_slot_q <= '0;
			byte_count_q  <= '0;
			countdown_q   <= '0;
		end else if (step_en) begin
			mode_q        <= mode_nx;
			armed_q       <= armed_nx;
			active_slot_q <= active_slot_nx;
			byte_count_q  <= byte_count_nx;
			countdown_q   <= countdown_nx;
		end
	end

`ifndef NO_ASSERTIONS
	// a finished packet leaves its slot disarmed
	a_done_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && emit && result.kind == cpr_pkg::KIND_DONE
		|=> (armed_q & (SLOT_ONE << $past(active_slot_q))) == '0)
		else $error("slot still armed after packet done");

	// awaiting a code byte only directly after a matched header
	a_code_after_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		$changed(mode_q) && mode_q == cpr_pkg::MODE_CODE
		|-> $past(mode_q) == cpr_pkg::MODE_CHAR)
		else $error("code mode entered from wrong mode");
`endif

endmodule

@@ rtl/cobs_packet_rx_demux.sv @@
// cobs_packet_rx_demux: text / COBS packet demultiplexer for a serial line.
// Throughput one item per cycle while the result channel is not stalled.
// Input register feeds the decode state machine, whose result lands in an output register.
// A stalled output holds the input register; the byte channel stalls only then.
// Reset (arst_n low, asynchronous): character mode, all slots disarmed,
// headers zero, packet length limit 253. Depends on cpr_pkg, cpr_cfg_regs, cpr_rx_core.
`timescale 1ns / 1ps

module cobs_packet_rx_demux #(
	parameter int LISTEN_SLOTS = 4,
	parameter int IDX_W        = $clog2(LISTEN_SLOTS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [7:0]         cfg_data,
	// received bytes and arm requests
	input  logic               byte_valid,
	output logic               byte_stall,
	input  cpr_pkg::in_item_t  byte_item,
	// decoded results
	output logic               result_valid,
	input  logic               result_stall,
	output cpr_pkg::out_item_t result_item
);

	logic [LISTEN_SLOTS-1:0][7:0] headers;
	logic [7:0]                   max_len;

	cpr_pkg::in_item_t  item_s1;
	logic               item_valid_s1;
	logic               step_en;
	logic               byte_xfer;
	logic               emit;
	cpr_pkg::out_item_t result;

	logic               res_valid_s2;
	cpr_pkg::out_item_t res_s2;

	// register file is always writable; writes must only come while idle, which the block itself does not enforce
	assign cfg_ready = 1'b1;

	cpr_cfg_regs #(
		.LISTEN_SLOTS (LISTEN_SLOTS),
		.IDX_W        (IDX_W)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.headers  (headers),
		.max_len  (max_len)
	);

	// the held item steps once the output register is free or draining
	assign step_en    = item_valid_s1 && (!res_valid_s2 || !result_stall);
	assign byte_stall = item_valid_s1 && !step_en;
	assign byte_xfer  = byte_valid && !byte_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (byte_xfer) begin
			item_valid_s1 <= 1'b1;
		end else if (step_en) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_xfer) begin
			item_s1 <= byte_item;
		end
	end

	cpr_rx_core #(
		.LISTEN_SLOTS (LISTEN_SLOTS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item    (item_s1),
		.headers (headers),
		.max_len (max_len),
		.emit    (emit),
		.result  (result)
	);

	// output register; items that give no result leave it empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (step_en) begin
			res_valid_s2 <= emit;
		end else if (!result_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && emit) begin
			res_s2 <= result;
		end
	end

	assign result_valid = res_valid_s2;
	assign result_item  = res_s2;

`ifndef NO_ASSERTIONS
	// a stalled result must block the decode step
	a_no_step_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> !step_en)
		else $error("decode stepped while result stalled");

	// byte channel stalls only behind a held item
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> item_valid_s1 && result_valid && result_stall)
		else $error("byte stall without a blocked item");

	// a result transfer with no new step empties the output register
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !step_en |=> !result_valid)
		else $error("result repeated after transfer");
`endif

endmodule

@@ tb/cobs_rx_checker.sv @@
// cobs_rx_checker: watches the config, byte and result channels of the demux,
// predicts each result and compares it with what comes out.
// Depends on cpr_pkg.
`timescale 1ns / 1ps

module cobs_rx_checker #(
	parameter int LISTEN_SLOTS = 4,
	parameter int IDX_W        = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               byte_valid,
	input  logic               byte_stall,
	input  cpr_pkg::in_item_t  byte_item,
	input  logic               result_valid,
	input  logic               result_stall,
	input  cpr_pkg::out_item_t result_item,
	output int                 mismatches,
	output int                 pending,
	output int                 checked,
	output int                 packets
);
	import cpr_pkg::*;

	// shadow registers
	logic [7:0] hdr [LISTEN_SLOTS];
	logic [7:0] len_limit;

	// receive state
	mode_t                   mode;
	logic [LISTEN_SLOTS-1:0] armed;
	logic [1:0]              cur_slot;
	logic [7:0]              enc_count;
	logic [7:0]              countdown;

	out_item_t expected_results [$];
	out_item_t predicted;
	out_item_t oldest;

	// advances the receive state by one transfer; returns 1 when a result is due
	function automatic bit demux_step(input in_item_t it, output out_item_t res);
		logic [7:0] b;
		bit         has;
		int         pick;
		has       = 1'b0;
		pick      = -1;
		b         = it.line_byte;
		res.kind  = KIND_TEXT;
		res.slot  = 2'd0;
		res.value = 8'd0;
		if (it.operation == OP_ARM) begin
			if (it.arm_slot < LISTEN_SLOTS)
				armed[it.arm_slot] = 1'b1;
			return 1'b0;
		end
		case (mode)
			MODE_CHAR: begin
				if ((b & HDR_FLAG) == 8'h00) begin
					if (b != DELIM) begin
						res.value = b;
						has       = 1'b1;
					end
				end else begin
					// scan downward so the lowest matching slot is kept
					for (int s = LISTEN_SLOTS - 1; s >= 0; s--)
						if (armed[s] && hdr[s] == b)
							pick = s;
					if (pick >= 0) begin
						cur_slot  = 2'(pick);
						enc_count = 8'd0;
						mode      = MODE_CODE;
					end else begin
						mode      = MODE_DISCARD;
						res.kind  = KIND_NOLISTEN;
						res.value = b;
						has       = 1'b1;
					end
				end
			end
			MODE_DISCARD: begin
				if (b == DELIM)
					mode = MODE_CHAR;
			end
			MODE_CODE: begin
				if (b == DELIM) begin
					mode     = MODE_CHAR;
					res.kind = KIND_EARLY;
					res.slot = cur_slot;
					has      = 1'b1;
				end else begin
					countdown = b;
					mode      = MODE_DATA;
				end
			end
			default: begin
				res.slot = cur_slot;
				has      = 1'b1;
				if (b == DELIM) begin
					armed[cur_slot] = 1'b0;
					mode            = MODE_CHAR;
					res.kind        = KIND_DONE;
					res.value       = enc_count;
				end else if (enc_count >= len_limit) begin
					mode     = MODE_DISCARD;
					res.kind = KIND_LONG;
				end else begin
					enc_count = enc_count + 8'd1;
					countdown = countdown - 8'd1;
					res.kind  = KIND_DATA;
					// countdown expiry marks a code byte: decodes to zero and reloads
					if (countdown == 8'd0) begin
						countdown = b;
						res.value = 8'd0;
					end else begin
						res.value = b;
					end
				end
			end
		endcase
		return has;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LISTEN_SLOTS; i++)
				hdr[i] = 8'd0;
			len_limit  = MAX_LEN_RESET;
			mode       = MODE_CHAR;
			armed      = '0;
			cur_slot   = 2'd0;
			enc_count  = 8'd0;
			countdown  = 8'd0;
			mismatches = 0;
			pending    = 0;
			checked    = 0;
			packets    = 0;
			expected_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < LISTEN_SLOTS)
					hdr[cfg_index] = cfg_data;
				else if (cfg_index == LISTEN_SLOTS)
					len_limit = cfg_data;
			end
			// push before pop: a result leaving now belongs to an older transfer
			if (byte_valid && !byte_stall) begin
				if (demux_step(byte_item, predicted))
					expected_results.push_back(predicted);
			end
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: kind %0d slot %0d value 0x%02h",
						result_item.kind, result_item.slot, result_item.value);
					mismatches++;
				end else begin
					oldest = expected_results.pop_front();
					checked++;
					if (oldest.kind == KIND_DONE)
						packets++;
					if (result_item.kind !== oldest.kind) begin
						$error("kind: expected %0d, actual %0d", oldest.kind, result_item.kind);
						mismatches++;
					end
					if (result_item.slot !== oldest.slot) begin
						$error("slot: expected %0d, actual %0d", oldest.slot, result_item.slot);
						mismatches++;
					end
					if (result_item.value !== oldest.value) begin
						$error("value: expected 0x%02h, actual 0x%02h",
							oldest.value, result_item.value);
						mismatches++;
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

@@ tb/tb_cobs_packet_rx_demux.sv @@
// tb_cobs_packet_rx_demux: stimulus and verdict for the COBS packet receive demux.
// Drives config writes, line bytes and arm requests; checking lives in cobs_rx_checker.
// Depends on cpr_pkg, cobs_packet_rx_demux, cobs_rx_checker.
`timescale 1ns / 1ps

module tb_cobs_packet_rx_demux;
	import cpr_pkg::*;

	localparam int LISTEN_SLOTS = 4;
	localparam int IDX_W        = 3;

	// register map
	localparam logic [IDX_W-1:0] REG_HDR_BASE = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAX_LEN  = 3'd4;
	localparam logic [IDX_W-1:0] REG_SPARE    = 3'd5;   // decodes to nothing

	localparam int ITEM_TARGET    = 1650;
	localparam int RANDOM_PHASES  = 6;
	localparam int HOLD_CYCLES    = 200;   // long receiver hold-off, fills the pipe
	localparam int IDLE_LIMIT     = 4000;  // cycles with no transfer anywhere
	localparam int TAIL_CYCLES    = 8;
	localparam int SETTLE_CYCLES  = 4;     // covers result-less items still held in the input register

	logic       clk    = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [7:0] cfg_data;
	logic       byte_valid;
	logic       byte_stall;
	in_item_t   byte_item;
	logic       result_valid;
	logic       result_stall;
	out_item_t  result_item;

	int mismatches;
	int pending;
	int checked;
	int packets;

	int hold_reqs   = 0;   // bumped by stimulus, served by the receiver process
	int idle_cycles = 0;
	int burst_left  = 0;
	int items_sent  = 0;
	int directed_items;
	int settings_used = 0;
	bit last_noise  = 1'b0;

	// local copy of the headers, only used to aim packets at real listeners
	logic [7:0] hdr_cfg [LISTEN_SLOTS];

	cobs_packet_rx_demux #(
		.LISTEN_SLOTS(LISTEN_SLOTS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_item   (byte_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item)
	);

	cobs_rx_checker #(
		.LISTEN_SLOTS(LISTEN_SLOTS),
		.IDX_W       (IDX_W)
	) demux_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_item   (byte_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item),
		.mismatches  (mismatches),
		.pending     (pending),
		.checked     (checked),
		.packets     (packets)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: any transfer on any channel resets the count. A hung DUT or a
	// result that never shows up ends the run here.
	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (byte_valid && !byte_stall) ||
				(result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles, %0d results outstanding",
					IDLE_LIMIT, pending);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Receiver: stall probability changes in stretches of random length, some
	// stretches never stall. A hold request forces a long solid stall.
	initial begin
		int stall_pct;
		int stretch_left;
		int hold_left;
		int holds_served;
		result_stall = 1'b0;
		stall_pct    = 0;
		stretch_left = 0;
		hold_left    = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (stretch_left == 0) begin
				case ($urandom_range(0, 4))
					0, 1: stall_pct = 0;
					2: stall_pct = 20;
					3: stall_pct = 50;
					default: stall_pct = 85;
				endcase
				stretch_left = $urandom_range(16, 160);
			end
			stretch_left--;
			if (holds_served != hold_reqs) begin
				holds_served = hold_reqs;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// One config transfer. cfg_valid is left high so back-to-back writes
	// don't drop and re-raise it in the same step; set_regs lowers it.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [7:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx < LISTEN_SLOTS)
			hdr_cfg[idx] = val;
	endtask

	task automatic set_regs(input logic [7:0] h0, input logic [7:0] h1,
			input logic [7:0] h2, input logic [7:0] h3, input logic [7:0] max_len);
		write_reg(REG_HDR_BASE + 3'd0, h0);
		write_reg(REG_HDR_BASE + 3'd1, h1);
		write_reg(REG_HDR_BASE + 3'd2, h2);
		write_reg(REG_HDR_BASE + 3'd3, h3);
		write_reg(REG_MAX_LEN, max_len);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Sender works in bursts; between bursts valid drops for a random gap, or stays high when the gap is zero.
	// Some bursts are long so there are stretches with no idling at all.
	task automatic send_item(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		byte_item  <= it;
		byte_valid <= 1'b1;
		do @(posedge clk); while (byte_stall);
		items_sent++;
	endtask

	// arm_slot is don't-care on a line byte; randomize it so its bits toggle
	task automatic send_byte(input logic [7:0] b);
		in_item_t it;
		it.operation = OP_BYTE;
		it.line_byte = b;
		it.arm_slot  = 2'($urandom);
		send_item(it);
	endtask

	task automatic send_arm(input logic [1:0] s);
		in_item_t it;
		it.operation = OP_ARM;
		it.line_byte = 8'($urandom);
		it.arm_slot  = s;
		send_item(it);
	endtask

	// Wait for the block to go quiet before touching registers.
	task automatic drain();
		byte_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] random_header();
		return 8'($urandom_range(128, 255));
	endfunction

	// Header, COBS-encoded payload, delimiter. flaw 1 puts a zero where the
	// code byte goes; flaw 2 overwrites one encoded byte with anything.
	task automatic send_packet(input logic [7:0] header, input int payload_len,
			input int flaw);
		logic [7:0] enc [$];
		logic [7:0] data;
		int         code_pos;
		code_pos = 0;
		enc.push_back(8'h01);
		for (int i = 0; i < payload_len; i++) begin
			data = ($urandom_range(0, 3) == 0) ? DELIM : 8'($urandom_range(1, 255));
			if (data == DELIM) begin
				code_pos = enc.size();
				enc.push_back(8'h01);
			end else begin
				enc.push_back(data);
				enc[code_pos] = enc[code_pos] + 8'd1;
				// full 254-byte block: next block starts with no implied zero
				if (enc[code_pos] == 8'hFF) begin
					code_pos = enc.size();
					enc.push_back(8'h01);
				end
			end
		end
		if (flaw == 1)
			enc[0] = DELIM;
		else if (flaw == 2 && enc.size() > 1)
			enc[$urandom_range(1, enc.size() - 1)] = 8'($urandom);
		send_byte(header);
		foreach (enc[i])
			send_byte(enc[i]);
		send_byte(DELIM);
	endtask

	task automatic random_traffic(input int item_goal, input bit with_hold);
		int unit;
		int n;
		int s;
		logic [7:0] header;
		unit = 0;
		while (items_sent < item_goal) begin
			// long hold-off early in the phase while bytes keep coming
			if (with_hold && unit == 5)
				hold_reqs <= hold_reqs + 1;
			unit++;
			n = $urandom_range(0, 99);
			if (n < 20) begin
				// text run, zeros included (dropped delimiters)
				repeat ($urandom_range(1, 8))
					send_byte(8'($urandom_range(0, 127)));
				last_noise = 1'b0;
			end else if (n < 80) begin
				if (last_noise)
					send_byte(DELIM);
				s = $urandom_range(0, LISTEN_SLOTS - 1);
				if ($urandom_range(0, 9) < 8)
					send_arm(2'(s));
				header = ($urandom_range(0, 5) == 0) ? random_header() : hdr_cfg[s];
				// mostly short packets; a few run past the length limits
				if ($urandom_range(0, 19) == 0)
					send_packet(header, $urandom_range(240, 262), $urandom_range(0, 9));
				else
					send_packet(header, $urandom_range(0, 12), $urandom_range(0, 9));
				last_noise = 1'b0;
			end else begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 2) == 0)
						send_arm(2'($urandom));
					else
						send_byte(8'($urandom));
				end
				last_noise = 1'b1;
			end
		end
	endtask

	initial begin
		int per_phase;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = 8'd0;
		byte_valid = 1'b0;
		byte_item  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: slot 0 and 2 share a header (lowest wins), slot 3 has
		// a header below 0x80 that can never match, limit of 3 data bytes
		set_regs(8'h80, 8'hFF, 8'h80, 8'h41, 8'd3);
		send_byte(8'h01);          // smallest text char
		send_byte(8'h7F);          // largest text char
		send_byte(DELIM);          // bare delimiter, dropped
		send_byte(8'hFF);          // header with no armed listener
		send_byte(8'h55);          // swallowed while discarding
		send_byte(DELIM);
		send_arm(2'd0);
		send_arm(2'd2);
		send_arm(2'd0);            // already armed
		send_byte(8'h80);          // slot 0 wins over slot 2
		send_arm(2'd0);            // arming the slot in flight
		send_byte(8'h02);          // code byte
		send_byte(8'h11);
		send_byte(8'h03);          // countdown expiry: decodes to zero
		send_byte(8'h22);
		send_byte(8'h33);          // fourth data byte, over the limit
		send_byte(DELIM);
		send_byte(8'h80);          // slot 0 still armed after overrun
		send_byte(DELIM);          // zero where the code byte belongs
		send_byte(8'h80);
		send_byte(8'h01);
		send_byte(DELIM);          // empty packet completes, slot 0 disarmed
		send_byte(8'h80);          // now slot 2 takes it
		send_byte(8'h01);
		send_byte(DELIM);
		directed_items = items_sent;
		drain();

		// --- random phases, each under its own register setting
		per_phase = (ITEM_TARGET - directed_items) / RANDOM_PHASES;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: set_regs(8'h00, 8'h81, 8'h9A, 8'hFF, 8'd0);   // limit 0: every data byte overruns
				1: set_regs(random_header(), random_header(), random_header(),
					random_header(), 8'd1);
				2: set_regs(8'h80, 8'h80, 8'hC3, 8'hFE, 8'd255);
				3: begin
					write_reg(REG_SPARE, 8'($urandom));  // no register behind it
					set_regs(random_header(), 8'($urandom), random_header(),
						random_header(), 8'($urandom_range(1, 253)));
				end
				4: set_regs(8'hFF, 8'hA0, 8'hB0, 8'h80, MAX_LEN_RESET);
				default: set_regs(random_header(), random_header(), 8'h80,
					random_header(), 8'd12);
			endcase
			last_noise = 1'b1;   // start each phase from a clean frame
			random_traffic(directed_items + (p + 1) * per_phase, (p == 1) || (p == 4));
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Summary: %0d items (%0d directed) under %0d register settings, limits 0 to 255.",
			items_sent, directed_items, settings_used);
		$display("Summary: %0d results compared, %0d packets completed, %0d receiver hold-offs.",
			checked, packets, hold_reqs);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
